FILE: sv/bpir_pkg.sv
// Package of the ball pair impulse resolver: field widths, internal word widths,
// register indexes and the structures passed between the pipeline modules.
// No dependencies.
package bpir_pkg;

   // Widths of the interface fields.
   localparam int POS_W = 24;
   localparam int VEL_W = 32;
   localparam int ELA_W = 9;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 1;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BALL_RADIUS = 1'b0,
      CSR_REST_THRESH = 1'b1
   } csr_idx_type;

   // Geometry words.
   localparam int D_W   = POS_W + 1;          // centre difference
   localparam int DV_W  = VEL_W + 1;          // velocity difference
   localparam int SQR_W = 2 * D_W - 1;        // one squared difference
   localparam int SQ_W  = 2 * D_W;            // squared distance
   localparam int PRD_W = D_W + DV_W;         // one dot product term
   localparam int DOT_W = PRD_W + 1;          // dot product
   localparam int LIM_W = 2 * CSR_W + 2;      // (2 * radius)^2
   localparam int F_W   = 11;                 // 512 + ea + eb
   localparam int F_BASE = 512;

   // Impulse words. Inside the contact distance |dx| and |dy| stay below 2^17,
   // which bounds the numerator, the denominator and the quotient below.
   localparam int DM_W   = 17;
   localparam int NDOT_W = 51;
   localparam int T_W    = 62;
   localparam int T_LO_W = 31;
   localparam int P_W    = T_LO_W + DM_W;
   localparam int NUM_W  = T_W + DM_W;
   localparam int DEN_SH = 10;
   localparam int DEN_W  = 45;
   localparam int Q_W    = 35;
   localparam int J_W    = Q_W + 1;
   localparam int S_W    = Q_W + 2;
   localparam int PRE_N  = 4;

   typedef struct packed {
      logic signed [POS_W-1:0] ax;
      logic signed [POS_W-1:0] ay;
      logic signed [VEL_W-1:0] avx;
      logic signed [VEL_W-1:0] avy;
      logic [ELA_W-1:0]        ea;
      logic signed [POS_W-1:0] bx;
      logic signed [POS_W-1:0] by;
      logic signed [VEL_W-1:0] bvx;
      logic signed [VEL_W-1:0] bvy;
      logic [ELA_W-1:0]        eb;
   } pair_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] avx;
      logic signed [VEL_W-1:0] avy;
      logic signed [VEL_W-1:0] bvx;
      logic signed [VEL_W-1:0] bvy;
   } vel_type;

   typedef struct packed {
      logic                    near;
      logic                    zero;
      logic signed [DOT_W-1:0] dot;
      logic [SQ_W-1:0]         dsq;
      logic signed [D_W-1:0]   dx;
      logic signed [D_W-1:0]   dy;
      logic [F_W-1:0]          f;
      vel_type                 v;
   } geom_type;

   typedef struct packed {
      logic    hit;
      logic    same;
      logic    sx;
      logic    sy;
      vel_type v;
   } side_type;

   typedef struct packed {
      logic    collided;
      logic    coincide;
      vel_type v;
      logic    a_rest;
      logic    b_rest;
   } result_type;

endpackage

FILE: sv/bpir_req_if.sv
// Request channel of the ball pair impulse resolver: one ball pair per word.
// Depends on bpir_pkg.
interface bpir_req_if;
   import bpir_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] ball_a_x;
   logic signed [POS_W-1:0] ball_a_y;
   logic signed [VEL_W-1:0] ball_a_vx;
   logic signed [VEL_W-1:0] ball_a_vy;
   logic [ELA_W-1:0]        ball_a_elasticity;
   logic signed [POS_W-1:0] ball_b_x;
   logic signed [POS_W-1:0] ball_b_y;
   logic signed [VEL_W-1:0] ball_b_vx;
   logic signed [VEL_W-1:0] ball_b_vy;
   logic [ELA_W-1:0]        ball_b_elasticity;

   modport source (
      output valid, ball_a_x, ball_a_y, ball_a_vx, ball_a_vy, ball_a_elasticity,
      output ball_b_x, ball_b_y, ball_b_vx, ball_b_vy, ball_b_elasticity,
      input  ready
   );
   modport sink (
      input  valid, ball_a_x, ball_a_y, ball_a_vx, ball_a_vy, ball_a_elasticity,
      input  ball_b_x, ball_b_y, ball_b_vx, ball_b_vy, ball_b_elasticity,
      output ready
   );
endinterface

FILE: sv/bpir_rsp_if.sv
// Response channel of the ball pair impulse resolver: one result per word.
// Depends on bpir_pkg.
interface bpir_rsp_if;
   import bpir_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    collided;
   logic                    centres_coincide;
   logic signed [VEL_W-1:0] new_a_vx;
   logic signed [VEL_W-1:0] new_a_vy;
   logic signed [VEL_W-1:0] new_b_vx;
   logic signed [VEL_W-1:0] new_b_vy;
   logic                    a_at_rest;
   logic                    b_at_rest;

   modport source (
      output valid, collided, centres_coincide, new_a_vx, new_a_vy, new_b_vx,
      output new_b_vy, a_at_rest, b_at_rest,
      input  ready
   );
   modport sink (
      input  valid, collided, centres_coincide, new_a_vx, new_a_vy, new_b_vx,
      input  new_b_vy, a_at_rest, b_at_rest,
      output ready
   );
endinterface

FILE: sv/ball_pair_impulse_resolver_top.sv
// Ball pair impulse resolver, top level.
// A pair of equal balls arrives as one word on req_chan (valid/ready); the
// result word leaves on rsp_chan (valid/ready). An item is taken at a clock
// edge where valid and ready are both high. The configuration port writes
// the ball radius (index 0) and the rest speed threshold (index 1) whenever
// csr_wr_en is high; write it only while no pair is in flight.
// Throughput is one pair per cycle unless the receiver stalls. The pipeline has
// three stages of geometry, four stages forming the impulse numerator, 35 stages of
// the bit-per-stage divider (one per quotient bit, two dividers side by side)
// and three stages applying the impulse and testing for rest, the last of
// which is the output register.
// The whole pipeline advances when the output register is empty or taken;
// when it is full and the receiver holds ready low every stage holds its word
// and req_chan.ready drops in the same cycle, so nothing is lost or repeated.
// A synchronous reset empties the pipeline and restores the radius to 2560
// and the threshold to 4; it needs no clearing pass.
// Depends on bpir_pkg, the channel interfaces and the pipeline modules.
module ball_pair_impulse_resolver_top (
   input  logic                           clock,
   input  logic                           reset,
   bpir_req_if.sink                       req_chan,
   bpir_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [bpir_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpir_pkg::CSR_W-1:0]     csr_wdata
);
   import bpir_pkg::*;

   localparam logic [CSR_W-1:0] RADIUS_RST = CSR_W'(2560);
   localparam logic [CSR_W-1:0] THRESH_RST = CSR_W'(4);

   logic [CSR_W-1:0] radius_ff, radius_in;
   logic [CSR_W-1:0] thresh_ff, thresh_in;
   logic             adv;
   pair_type         pair;
   logic             geom_vld, imp_vld, res_vld;
   geom_type         geom;
   side_type         side;
   logic [Q_W-1:0]   qx, qy;
   result_type       res;

   // Configuration registers.
   always_comb begin
      radius_in = radius_ff;
      thresh_in = thresh_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BALL_RADIUS: radius_in = csr_wdata;
            CSR_REST_THRESH: thresh_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         thresh_ff <= THRESH_RST;
      end else begin
         radius_ff <= radius_in;
         thresh_ff <= thresh_in;
      end
   end

   // Pipeline advance: the output register is free or being emptied.
   assign adv            = !res_vld || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      pair.ax  = req_chan.ball_a_x;
      pair.ay  = req_chan.ball_a_y;
      pair.avx = req_chan.ball_a_vx;
      pair.avy = req_chan.ball_a_vy;
      pair.ea  = req_chan.ball_a_elasticity;
      pair.bx  = req_chan.ball_b_x;
      pair.by  = req_chan.ball_b_y;
      pair.bvx = req_chan.ball_b_vx;
      pair.bvy = req_chan.ball_b_vy;
      pair.eb  = req_chan.ball_b_elasticity;
   end

   bpir_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_vld      (req_chan.valid),
      .in_pair     (pair),
      .ball_radius (radius_ff),
      .out_vld     (geom_vld),
      .out_geom    (geom)
   );

   bpir_impulse u_impulse (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (geom_vld),
      .in_geom  (geom),
      .out_vld  (imp_vld),
      .qx       (qx),
      .qy       (qy),
      .out_side (side)
   );

   bpir_back u_back (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_vld      (imp_vld),
      .in_side     (side),
      .qx          (qx),
      .qy          (qy),
      .rest_thresh (thresh_ff),
      .out_vld     (res_vld),
      .out_res     (res)
   );

   // Result word.
   assign rsp_chan.valid            = res_vld;
   assign rsp_chan.collided         = res.collided;
   assign rsp_chan.centres_coincide = res.coincide;
   assign rsp_chan.new_a_vx         = res.v.avx;
   assign rsp_chan.new_a_vy         = res.v.avy;
   assign rsp_chan.new_b_vx         = res.v.bvx;
   assign rsp_chan.new_b_vy         = res.v.bvy;
   assign rsp_chan.a_at_rest        = res.a_rest;
   assign rsp_chan.b_at_rest        = res.b_rest;

   // Coincident centres are only ever reported as part of a collision.
   a_coincide_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.centres_coincide |-> rsp_chan.collided)
      else $error("coincident centres reported without a collision");

endmodule

FILE: sv/bpir_div.sv
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// The caller guarantees the quotient fits in Q_W bits. Depends on nothing.
module bpir_div #(
   parameter int NUM_W = 79,
   parameter int DEN_W = 45,
   parameter int Q_W   = 35
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo
);

   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [Q_W-1:0]   low_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];

   genvar s;
   generate
      for (s = 0; s < Q_W; s++) begin : g_stage
         logic [DEN_W-1:0] rem_prev;
         logic [Q_W-1:0]   low_prev;
         logic [DEN_W-1:0] den_prev;
         logic [Q_W-1:0]   quo_prev;
         logic [DEN_W:0]   trial;
         logic [DEN_W:0]   diff;
         logic             ge;
         logic [DEN_W-1:0] rem_in;
         logic [Q_W-1:0]   low_in;
         logic [Q_W-1:0]   quo_in;

         // The first stage takes the high numerator bits as its remainder.
         if (s == 0) begin : g_first
            assign rem_prev = DEN_W'(num[NUM_W-1:Q_W]);
            assign low_prev = num[Q_W-1:0];
            assign den_prev = den;
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[s-1];
            assign low_prev = low_ff[s-1];
            assign den_prev = den_ff[s-1];
            assign quo_prev = quo_ff[s-1];
         end

         // Shift in the next numerator bit and subtract where the divisor fits.
         always_comb begin
            trial  = {rem_prev, low_prev[Q_W-1]};
            diff   = trial - {1'b0, den_prev};
            ge     = trial >= {1'b0, den_prev};
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_in = low_prev << 1;
            quo_in = {quo_prev[Q_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s] <= rem_in;
               low_ff[s] <= low_in;
               den_ff[s] <= den_prev;
               quo_ff[s] <= quo_in;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[Q_W-1];

endmodule

FILE: sv/bpir_front.sv
// Front end of the resolver: differences, squares and dot product, and the
// contact distance test, over three stages. Depends on bpir_pkg.
module bpir_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_vld,
   input  bpir_pkg::pair_type        in_pair,
   input  logic [bpir_pkg::CSR_W-1:0] ball_radius,
   output logic                      out_vld,
   output bpir_pkg::geom_type        out_geom
);
   import bpir_pkg::*;

   logic [2:0] vld_ff, vld_in;

   logic signed [D_W-1:0]  dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic signed [DV_W-1:0] dvx1_ff, dvy1_ff, dvx1_in, dvy1_in;
   logic [F_W-1:0]         f1_ff, f1_in;
   logic [LIM_W-1:0]       lim1_ff, lim1_in;
   vel_type                v1_ff, v1_in;
   logic [2*CSR_W-1:0]     rr;

   logic [SQR_W-1:0]        sxx2_ff, syy2_ff, sxx2_in, syy2_in;
   logic signed [PRD_W-1:0] pxx2_ff, pyy2_ff, pxx2_in, pyy2_in;
   logic signed [SQ_W-1:0]  mxx, myy;
   logic signed [D_W-1:0]   dx2_ff, dy2_ff;
   logic [F_W-1:0]          f2_ff;
   logic [LIM_W-1:0]        lim2_ff;
   vel_type                 v2_ff;

   geom_type geom3_ff, geom3_in;

   // Valid bits travel with the data.
   assign vld_in = {vld_ff[1:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage one: centre and velocity differences, restitution sum, limit.
   always_comb begin
      dx1_in  = D_W'(in_pair.ax) - D_W'(in_pair.bx);
      dy1_in  = D_W'(in_pair.ay) - D_W'(in_pair.by);
      dvx1_in = DV_W'(in_pair.avx) - DV_W'(in_pair.bvx);
      dvy1_in = DV_W'(in_pair.avy) - DV_W'(in_pair.bvy);
      f1_in   = F_W'(F_BASE) + F_W'(in_pair.ea) + F_W'(in_pair.eb);
      rr      = (2*CSR_W)'(ball_radius) * (2*CSR_W)'(ball_radius);
      lim1_in = {rr, 2'b00};
      v1_in   = '{avx: in_pair.avx, avy: in_pair.avy, bvx: in_pair.bvx, bvy: in_pair.bvy};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         dvx1_ff <= dvx1_in;
         dvy1_ff <= dvy1_in;
         f1_ff   <= f1_in;
         lim1_ff <= lim1_in;
         v1_ff   <= v1_in;
      end
   end

   // Stage two: the four products.
   always_comb begin
      mxx     = dx1_ff * dx1_ff;
      myy     = dy1_ff * dy1_ff;
      sxx2_in = mxx[SQR_W-1:0];
      syy2_in = myy[SQR_W-1:0];
      pxx2_in = dvx1_ff * dx1_ff;
      pyy2_in = dvy1_ff * dy1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sxx2_ff <= sxx2_in;
         syy2_ff <= syy2_in;
         pxx2_ff <= pxx2_in;
         pyy2_ff <= pyy2_in;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         f2_ff   <= f1_ff;
         lim2_ff <= lim1_ff;
         v2_ff   <= v1_ff;
      end
   end

   // Stage three: squared distance, dot product and the contact test.
   always_comb begin
      geom3_in.dsq  = SQ_W'(sxx2_ff) + SQ_W'(syy2_ff);
      geom3_in.dot  = DOT_W'(pxx2_ff) + DOT_W'(pyy2_ff);
      geom3_in.near = geom3_in.dsq <= SQ_W'(lim2_ff);
      geom3_in.zero = geom3_in.dsq == '0;
      geom3_in.dx   = dx2_ff;
      geom3_in.dy   = dy2_ff;
      geom3_in.f    = f2_ff;
      geom3_in.v    = v2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geom3_ff <= geom3_in;
      end
   end

   assign out_vld  = vld_ff[2];
   assign out_geom = geom3_ff;

endmodule

FILE: sv/bpir_impulse.sv
// Impulse magnitude: collision decision, numerator products and two pipelined
// dividers for the x and y parts. Depends on bpir_pkg and bpir_div.
module bpir_impulse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_vld,
   input  bpir_pkg::geom_type       in_geom,
   output logic                     out_vld,
   output logic [bpir_pkg::Q_W-1:0] qx,
   output logic [bpir_pkg::Q_W-1:0] qy,
   output bpir_pkg::side_type       out_side
);
   import bpir_pkg::*;

   localparam int SIDE_N = PRE_N + Q_W;

   logic [SIDE_N-1:0] vld_ff, vld_in;
   side_type          side_ff [SIDE_N];
   side_type          side_in [SIDE_N];

   logic [NDOT_W-1:0]     ndot4_ff, ndot4_in;
   logic [F_W-1:0]        f4_ff;
   logic [DM_W-1:0]       mcx4_ff, mcy4_ff, mcx4_in, mcy4_in;
   logic [DEN_W-1:0]      den4_ff, den4_in;
   logic signed [DOT_W-1:0] ndot;
   logic signed [D_W-1:0] adx, ady;

   logic [T_W-1:0]   t5_ff, t5_in;
   logic [DM_W-1:0]  mcx5_ff, mcy5_ff;
   logic [DEN_W-1:0] den5_ff;

   logic [P_W-1:0]   plox6_ff, phix6_ff, ploy6_ff, phiy6_ff;
   logic [P_W-1:0]   plox6_in, phix6_in, ploy6_in, phiy6_in;
   logic [DEN_W-1:0] den6_ff;

   logic [NUM_W-1:0] numx7_ff, numy7_ff, numx7_in, numy7_in;
   logic [DEN_W-1:0] den7_ff;

   assign vld_in = {vld_ff[SIDE_N-2:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage four: the pair collides when near and not separating. The
   // magnitude of the dot product is only needed when it is not positive.
   always_comb begin
      side_in[0].hit  = in_geom.near && (in_geom.dot[DOT_W-1] || in_geom.dot == '0);
      side_in[0].same = in_geom.zero;
      side_in[0].sx   = in_geom.dx[D_W-1];
      side_in[0].sy   = in_geom.dy[D_W-1];
      side_in[0].v    = in_geom.v;
      ndot     = -in_geom.dot;
      ndot4_in = ndot[NDOT_W-1:0];
      adx      = in_geom.dx[D_W-1] ? -in_geom.dx : in_geom.dx;
      ady      = in_geom.dy[D_W-1] ? -in_geom.dy : in_geom.dy;
      mcx4_in  = adx[DM_W-1:0];
      mcy4_in  = ady[DM_W-1:0];
      den4_in  = {in_geom.dsq[DEN_W-DEN_SH-1:0], {DEN_SH{1'b0}}};
   end

   // Side information follows the item through every stage.
   genvar k;
   generate
      for (k = 1; k < SIDE_N; k++) begin : g_side
         assign side_in[k] = side_ff[k-1];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < SIDE_N; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ndot4_ff <= ndot4_in;
         f4_ff    <= in_geom.f;
         mcx4_ff  <= mcx4_in;
         mcy4_ff  <= mcy4_in;
         den4_ff  <= den4_in;
      end
   end

   // Stage five: scale the dot product by the restitution sum.
   assign t5_in = T_W'(ndot4_ff) * T_W'(f4_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         t5_ff   <= t5_in;
         mcx5_ff <= mcx4_ff;
         mcy5_ff <= mcy4_ff;
         den5_ff <= den4_ff;
      end
   end

   // Stage six: partial products of the numerators.
   always_comb begin
      plox6_in = P_W'(t5_ff[T_LO_W-1:0]) * P_W'(mcx5_ff);
      phix6_in = P_W'(t5_ff[T_W-1:T_LO_W]) * P_W'(mcx5_ff);
      ploy6_in = P_W'(t5_ff[T_LO_W-1:0]) * P_W'(mcy5_ff);
      phiy6_in = P_W'(t5_ff[T_W-1:T_LO_W]) * P_W'(mcy5_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plox6_ff <= plox6_in;
         phix6_ff <= phix6_in;
         ploy6_ff <= ploy6_in;
         phiy6_ff <= phiy6_in;
         den6_ff  <= den5_ff;
      end
   end

   // Stage seven: combine the partial products.
   always_comb begin
      numx7_in = NUM_W'(plox6_ff) + (NUM_W'(phix6_ff) << T_LO_W);
      numy7_in = NUM_W'(ploy6_ff) + (NUM_W'(phiy6_ff) << T_LO_W);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         numx7_ff <= numx7_in;
         numy7_ff <= numy7_in;
         den7_ff  <= den6_ff;
      end
   end

   bpir_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (numx7_ff),
      .den   (den7_ff),
      .quo   (qx)
   );

   bpir_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (numy7_ff),
      .den   (den7_ff),
      .quo   (qy)
   );

   assign out_vld  = vld_ff[SIDE_N-1];
   assign out_side = side_ff[SIDE_N-1];

   // A collision with separate centres must never reach the divider with a
   // zero divisor.
   a_den_nonzero : assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && side_ff[0].hit && !side_ff[0].same |-> den4_ff != '0)
      else $error("zero divisor on a collision with separate centres");

endmodule

FILE: sv/bpir_back.sv
// Back end of the resolver: applies the impulse with saturation, then the two
// rest tests; the last stage is the output register. Depends on bpir_pkg.
module bpir_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_vld,
   input  bpir_pkg::side_type         in_side,
   input  logic [bpir_pkg::Q_W-1:0]   qx,
   input  logic [bpir_pkg::Q_W-1:0]   qy,
   input  logic [bpir_pkg::CSR_W-1:0] rest_thresh,
   output logic                       out_vld,
   output bpir_pkg::result_type       out_res
);
   import bpir_pkg::*;

   localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
   localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
   localparam int SQ2_W = 2 * VEL_W;
   localparam int SP_W  = SQ2_W + 1;

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [S_W-1:0] s);
      logic signed [VEL_W-1:0] r;
      if (s > S_W'(VEL_MAX)) begin
         r = VEL_MAX;
      end else if (s < S_W'(VEL_MIN)) begin
         r = VEL_MIN;
      end else begin
         r = s[VEL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [VEL_W-1:0] mag(input logic signed [VEL_W-1:0] v);
      logic signed [VEL_W-1:0] n;
      n = -v;
      return v[VEL_W-1] ? n : v;
   endfunction

   logic [2:0] vld_ff, vld_in;

   logic signed [J_W-1:0] qxs, qys, jx, jy;
   vel_type  v1_ff, v1_in;
   logic     hit1_ff, same1_ff;

   logic [VEL_W-1:0]   uax, uay, ubx, uby;
   logic [SQ2_W-1:0]   sax2_ff, say2_ff, sbx2_ff, sby2_ff;
   logic [SQ2_W-1:0]   sax2_in, say2_in, sbx2_in, sby2_in;
   logic [2*CSR_W-1:0] thr2_ff, thr2_in;
   vel_type            v2_ff;
   logic               hit2_ff, same2_ff;

   logic [SP_W-1:0] spa, spb;
   result_type      res3_ff, res3_in;

   assign vld_in = {vld_ff[1:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage one: signed impulse parts, added to A and taken from B.
   always_comb begin
      qxs = {1'b0, qx};
      qys = {1'b0, qy};
      jx  = in_side.sx ? -qxs : qxs;
      jy  = in_side.sy ? -qys : qys;
      if (in_side.hit && !in_side.same) begin
         v1_in.avx = sat_vel(S_W'(in_side.v.avx) + S_W'(jx));
         v1_in.avy = sat_vel(S_W'(in_side.v.avy) + S_W'(jy));
         v1_in.bvx = sat_vel(S_W'(in_side.v.bvx) - S_W'(jx));
         v1_in.bvy = sat_vel(S_W'(in_side.v.bvy) - S_W'(jy));
      end else begin
         v1_in = in_side.v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff    <= v1_in;
         hit1_ff  <= in_side.hit;
         same1_ff <= in_side.same;
      end
   end

   // Stage two: squared velocity components and squared threshold.
   always_comb begin
      uax     = mag(v1_ff.avx);
      uay     = mag(v1_ff.avy);
      ubx     = mag(v1_ff.bvx);
      uby     = mag(v1_ff.bvy);
      sax2_in = SQ2_W'(uax) * SQ2_W'(uax);
      say2_in = SQ2_W'(uay) * SQ2_W'(uay);
      sbx2_in = SQ2_W'(ubx) * SQ2_W'(ubx);
      sby2_in = SQ2_W'(uby) * SQ2_W'(uby);
      thr2_in = (2*CSR_W)'(rest_thresh) * (2*CSR_W)'(rest_thresh);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sax2_ff  <= sax2_in;
         say2_ff  <= say2_in;
         sbx2_ff  <= sbx2_in;
         sby2_ff  <= sby2_in;
         thr2_ff  <= thr2_in;
         v2_ff    <= v1_ff;
         hit2_ff  <= hit1_ff;
         same2_ff <= same1_ff;
      end
   end

   // Stage three: rest tests into the output register.
   always_comb begin
      spa              = SP_W'(sax2_ff) + SP_W'(say2_ff);
      spb              = SP_W'(sbx2_ff) + SP_W'(sby2_ff);
      res3_in.collided = hit2_ff;
      res3_in.coincide = same2_ff;
      res3_in.v        = v2_ff;
      res3_in.a_rest   = spa < SP_W'(thr2_ff);
      res3_in.b_rest   = spb < SP_W'(thr2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res3_ff <= res3_in;
      end
   end

   assign out_vld = vld_ff[2];
   assign out_res = res3_ff;

   // Without an impulse the velocities pass through unchanged.
   a_pass_through : assert property (@(posedge clock) disable iff (reset)
      adv && in_vld && (!in_side.hit || in_side.same) |=> v1_ff == $past(in_side.v))
      else $error("velocities altered without an impulse");

endmodule

FILE: verif/bpir_checker.sv
// Checker of the ball pair impulse resolver: watches the pair and result channels,
// predicts each result word and compares it. Depends on bpir_pkg and the channel
// interfaces.
`timescale 1ns / 1ps
module bpir_checker (
   input  logic         clock,
   input  logic         reset,
   bpir_req_if.sink     req_mon,
   bpir_rsp_if.sink     rsp_mon,
   input  logic         csr_wr_en,
   input  logic [bpir_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpir_pkg::CSR_W-1:0]     csr_wdata,
   output int           fail_count,
   output int           pending_count,
   output int           seen_hits,
   output int           seen_results
);
   import bpir_pkg::*;

   typedef struct {
      logic                    collided;
      logic                    coincide;
      logic signed [VEL_W-1:0] avx, avy, bvx, bvy;
      logic                    a_rest, b_rest;
   } outcome_type;

   outcome_type expected_results[$];
   logic [CSR_W-1:0] radius_q, thresh_q;

   // Impulse component: -(t * c) / den, truncated toward zero.
   function automatic longint impulse_share(longint t, longint c, longint unsigned den);
      logic [127:0] mag;
      logic [127:0] q;
      logic neg;
      neg = (t < 0) != (c < 0);
      mag = 128'(t < 0 ? -t : t) * 128'(c < 0 ? -c : c);
      q = mag / 128'(den);
      return neg ? longint'(q[63:0]) : -longint'(q[63:0]);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic below_rest(longint vx, longint vy);
      longint unsigned sp;
      sp = longint'(vx * vx) + longint'(vy * vy);
      return sp < longint'(thresh_q) * longint'(thresh_q);
   endfunction

   function automatic outcome_type resolve_pair();
      outcome_type o;
      longint dx, dy, dvx, dvy, dot, f, t, jx, jy;
      longint nax, nay, nbx, nby;
      longint unsigned dsq, lim;
      dx = longint'(req_mon.ball_a_x) - longint'(req_mon.ball_b_x);
      dy = longint'(req_mon.ball_a_y) - longint'(req_mon.ball_b_y);
      dsq = dx * dx + dy * dy;
      lim = 4 * longint'(radius_q) * longint'(radius_q);
      nax = req_mon.ball_a_vx; nay = req_mon.ball_a_vy;
      nbx = req_mon.ball_b_vx; nby = req_mon.ball_b_vy;
      o.collided = 0;
      o.coincide = 0;
      if (dsq <= lim) begin
         dvx = nax - nbx;
         dvy = nay - nby;
         dot = dvx * dx + dvy * dy;
         if (dot <= 0) begin
            o.collided = 1;
            if (dsq == 0) begin
               o.coincide = 1;
            end else begin
               f = 512 + longint'(req_mon.ball_a_elasticity)
                   + longint'(req_mon.ball_b_elasticity);
               t = dot * f;
               jx = impulse_share(t, dx, dsq << 10);
               jy = impulse_share(t, dy, dsq << 10);
               nax = clamp32(nax + jx);
               nay = clamp32(nay + jy);
               nbx = clamp32(nbx - jx);
               nby = clamp32(nby - jy);
            end
         end
      end
      o.avx = nax[31:0]; o.avy = nay[31:0];
      o.bvx = nbx[31:0]; o.bvy = nby[31:0];
      o.a_rest = below_rest(nax, nay);
      o.b_rest = below_rest(nbx, nby);
      return o;
   endfunction

   assign pending_count = expected_results.size();

   // Register copy, pair prediction and result comparison.
   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         radius_q <= 16'd2560;
         thresh_q <= 16'd4;
         fail_count <= 0;
         seen_hits <= 0;
         seen_results <= 0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_BALL_RADIUS) radius_q <= csr_wdata;
            else if (csr_index == CSR_REST_THRESH) thresh_q <= csr_wdata;
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(resolve_pair());
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_results <= seen_results + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: result word with nothing expected", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_results.pop_front();
               if (e.collided) seen_hits <= seen_hits + 1;
               if (e.collided !== rsp_mon.collided || e.coincide !== rsp_mon.centres_coincide
                   || e.avx !== rsp_mon.new_a_vx || e.avy !== rsp_mon.new_a_vy
                   || e.bvx !== rsp_mon.new_b_vx || e.bvy !== rsp_mon.new_b_vy
                   || e.a_rest !== rsp_mon.a_at_rest || e.b_rest !== rsp_mon.b_at_rest) begin
                  $display("%0t: mismatch expected hit=%b same=%b a=(%0d,%0d) b=(%0d,%0d) rest=%b%b",
                           $realtime, e.collided, e.coincide, e.avx, e.avy, e.bvx, e.bvy,
                           e.a_rest, e.b_rest);
                  $display("%0t:          actual   hit=%b same=%b a=(%0d,%0d) b=(%0d,%0d) rest=%b%b",
                           $realtime, rsp_mon.collided, rsp_mon.centres_coincide,
                           rsp_mon.new_a_vx, rsp_mon.new_a_vy, rsp_mon.new_b_vx,
                           rsp_mon.new_b_vy, rsp_mon.a_at_rest, rsp_mon.b_at_rest);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: verif/tb.sv
// Testbench top of the ball pair impulse resolver: clock, reset, pair stimulus,
// receiver stalls, register phases and the verdict. Depends on bpir_pkg, the
// channel interfaces, the block and bpir_checker.
`timescale 1ns / 1ps
module tb;
   import bpir_pkg::*;

   localparam int LATENCY = 45;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BALL_RADIUS;
   logic [CSR_W-1:0] csr_wdata = '0;
   int fail_count, pending_count, seen_hits, seen_results;
   int idle_cycles = 0;
   int pairs_sent = 0;
   logic long_hold = 0;
   logic stall_on = 0;
   logic [CSR_W-1:0] radius_now = 16'd2560;

   bpir_req_if req_chan ();
   bpir_rsp_if rsp_chan ();

   ball_pair_impulse_resolver_top u_top (
      .clock, .reset, .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_wr_en, .csr_index, .csr_wdata
   );

   bpir_checker u_checker (
      .clock, .reset, .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink),
      .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .pending_count, .seen_hits, .seen_results
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      req_chan.valid = 0;
      {req_chan.ball_a_x, req_chan.ball_a_y, req_chan.ball_a_vx, req_chan.ball_a_vy,
       req_chan.ball_a_elasticity, req_chan.ball_b_x, req_chan.ball_b_y,
       req_chan.ball_b_vx, req_chan.ball_b_vy, req_chan.ball_b_elasticity} = '0;
      rsp_chan.ready = 0;
   end

   // Receiver stalls: random pattern, with a long hold-off while it is asked for.
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else if (long_hold) rsp_chan.ready <= 0;
      else if (stall_on) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      else rsp_chan.ready <= 1;
   end

   always @(posedge clock) begin
      if (!stall_on || $urandom_range(0, 63) == 0) stall_on <= ($urandom_range(0, 2) != 0);
   end

   // Watchdog on cycles with no word accepted.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("tb failed");
            $finish;
         end
      end
   end

   // Long hold-off of the receiver, counted in its own process.
   task automatic hold_receiver(int cycles);
      long_hold <= 1;
      repeat (cycles) @(posedge clock);
      long_hold <= 0;
   endtask

   // One register write, followed by a cycle with the write enable low.
   task automatic write_reg(csr_idx_type idx, logic [CSR_W-1:0] value);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_BALL_RADIUS) radius_now = value;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic drain_block();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY / 4) @(posedge clock);
   endtask

   // Offers one pair word and holds it until accepted.
   task automatic send_pair(logic [POS_W-1:0] ax, ay, logic [VEL_W-1:0] avx, avy,
                            logic [ELA_W-1:0] ea, logic [POS_W-1:0] bx, by,
                            logic [VEL_W-1:0] bvx, bvy, logic [ELA_W-1:0] eb);
      req_chan.valid <= 1;
      req_chan.ball_a_x <= ax; req_chan.ball_a_y <= ay;
      req_chan.ball_a_vx <= avx; req_chan.ball_a_vy <= avy;
      req_chan.ball_a_elasticity <= ea;
      req_chan.ball_b_x <= bx; req_chan.ball_b_y <= by;
      req_chan.ball_b_vx <= bvx; req_chan.ball_b_vy <= bvy;
      req_chan.ball_b_elasticity <= eb;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pairs_sent++;
   endtask

   task automatic idle_gap(int cycles);
      req_chan.valid <= 0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [VEL_W-1:0] random_vel();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fff_ff00 + $urandom_range(0, 255)
                                        : 32'h8000_0000 + $urandom_range(0, 255);
         2: return $signed($urandom_range(0, 16)) - 8;
         default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
   endfunction

   // One random pair: mostly near each other so that contact is common.
   task automatic send_random_pair();
      logic [POS_W-1:0] ax, ay, bx, by;
      int span;
      span = 2 * radius_now + 2;
      ax = POS_W'($urandom());
      ay = POS_W'($urandom());
      if ($urandom_range(0, 9) < 8) begin
         bx = POS_W'(ax + ($signed($urandom_range(0, span)) - span / 2));
         by = POS_W'(ay + ($signed($urandom_range(0, span)) - span / 2));
         if ($urandom_range(0, 19) == 0) begin
            bx = ax;
            by = ay;
         end
      end else begin
         bx = POS_W'($urandom());
         by = POS_W'($urandom());
      end
      send_pair(ax, ay, random_vel(), random_vel(), ELA_W'($urandom_range(0, 511)),
                bx, by, random_vel(), random_vel(), ELA_W'($urandom_range(0, 511)));
   endtask

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 30);
         if (burst > count) burst = count;
         repeat (burst) begin
            send_random_pair();
            count--;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
      end
      req_chan.valid <= 0;
   endtask

   initial begin
      logic [CSR_W-1:0] radii[5];
      logic [CSR_W-1:0] threshs[5];
      radii = '{16'd2560, 16'd1, 16'd65535, 16'd0, 16'd300};
      threshs = '{16'd4, 16'd0, 16'd65535, 16'd1000, 16'd20};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed pairs at reset settings: contact, coincident centres, separating,
      // far apart, extremes of position, velocity and elasticity.
      send_pair(0, 0, 32'sd4096, 0, 256, 24'sd1280, 0, -32'sd4096, 0, 256);
      send_pair(100, 100, 32'sd4096, 32'sd100, 0, 100, 100, 0, 0, 0);
      send_pair(0, 0, -32'sd4096, 0, 256, 24'sd1280, 0, 32'sd4096, 0, 256);
      send_pair(0, 0, 0, 0, 0, 24'sd5120, 0, 0, 0, 0);
      send_pair(0, 0, 0, 0, 0, 24'sd5121, 0, 0, 0, 0);
      send_pair(24'h7fffff, 24'h7fffff, 32'h7fffffff, 32'h7fffffff, 511,
                24'h7ffffe, 24'h7ffffe, 32'h80000000, 32'h80000000, 511);
      send_pair(24'h800000, 24'h800000, 32'h80000000, 32'h80000000, 511,
                24'h800001, 24'h800000, 32'h7fffffff, 32'h7fffffff, 511);
      send_pair(24'h800000, 0, 0, 0, 0, 24'h7fffff, 0, 0, 0, 0);
      send_pair(0, 0, 32'hffffffff, 32'h7fffffff, 256, 0, 1, 32'h80000000, 1, 0);
      send_pair(0, 0, 1, 2, 3, 24'sd100, 24'sd100, 32'sd5, -32'sd6, 7);
      send_pair(0, 0, 0, 0, 511, 24'sd10, -24'sd10, 0, 0, 511);
      send_pair(24'h555555, 24'haaaaaa, 32'h55555555, 32'haaaaaaaa, 9'h155,
                24'h555556, 24'haaaaaa, 32'haaaaaaaa, 32'h55555555, 9'h0aa);
      req_chan.valid <= 0;
      drain_block();

      // Register phases, each followed by random pairs; the receiver holds off
      // for a long stretch in the first one.
      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_BALL_RADIUS, radii[p]);
         write_reg(CSR_REST_THRESH, threshs[p]);
         if (p == 0) fork
            hold_receiver(200);
         join_none
         random_phase(150);
         drain_block();
      end

      $display("sent %0d pairs over 5 register settings; %0d results, %0d with contact",
               pairs_sent, seen_results, seen_hits);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
